### hw/rtl/mhik_pkg.sv
`default_nettype none

package mhik_pkg;

    // request kind carried on the input tuser
    typedef enum logic
    {
        FUNC_INSERT = 1'b0,
        FUNC_INCR   = 1'b1
    } func_t;

    // result status carried on the output tuser
    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    localparam int ID_W    = 16;
    localparam int COUNT_W = 32;
    localparam int ECNT_W  = 7;

    // one heap slot
    typedef struct packed
    {
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
    } entry_t;

    // finished result handed from the sequencer to the output register
    typedef struct packed
    {
        status_t             status;
        logic [ID_W-1:0]     top_id;
        logic [COUNT_W-1:0]  top_count;
        logic [ECNT_W-1:0]   entry_count;
    } res_t;

endpackage

`default_nettype wire

### hw/rtl/mhik_ram.sv
`default_nettype none

module mhik_ram
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire mhik_pkg::entry_t  wdata,
    input  wire logic [AW-1:0]     raddr,
    output mhik_pkg::entry_t       rdata
);
    import mhik_pkg::*;

    entry_t mem [DEPTH];

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/mhik_ctrl.sv
`default_nettype none

module mhik_ctrl
#(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int FW       = 7
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire mhik_pkg::func_t              req_func,
    input  wire logic [mhik_pkg::ID_W-1:0]    req_id,
    input  wire logic [mhik_pkg::COUNT_W-1:0] req_count,
    output logic                              ready,
    output logic                              res_valid,
    output mhik_pkg::res_t                    res,
    input  wire logic                         res_take
);
    import mhik_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SEARCH,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_DONE
    } state_t;

    localparam logic [FW-1:0] CAP_F = FW'(CAPACITY);

    state_t            state_reg,  state_next;
    logic [FW-1:0]     fill_reg,   fill_next;
    logic [AW-1:0]     pos_reg,    pos_next;
    logic [AW-1:0]     scan_reg,   scan_next;
    logic [ID_W-1:0]   id_reg,     id_next;
    entry_t            ent_reg,    ent_next;
    entry_t            root_reg,   root_next;
    status_t           status_reg, status_next;

    logic              we;
    logic [AW-1:0]     waddr;
    entry_t            wdata;
    logic [AW-1:0]     raddr;
    entry_t            rdata;
    logic [AW-1:0]     parent;
    logic              scan_last;

    // shared compare unit: identifier match during search, count order during sift
    logic [COUNT_W-1:0] cmp_a;
    logic [COUNT_W-1:0] cmp_b;
    logic               cmp_eq;
    logic               cmp_gt;

    assign cmp_eq = (cmp_a == cmp_b);
    assign cmp_gt = (cmp_a > cmp_b);

    assign parent    = (pos_reg - AW'(1)) >> 1;
    assign scan_last = ((FW'(scan_reg) + FW'(1)) == fill_reg);

    mhik_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram
    (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        scan_next   = scan_reg;
        id_next     = id_reg;
        ent_next    = ent_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = ent_reg;
        raddr       = '0;
        cmp_a       = {{(COUNT_W-ID_W){1'b0}}, id_reg};
        cmp_b       = {{(COUNT_W-ID_W){1'b0}}, rdata.id};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    id_next     = req_id;
                    status_next = ST_OK;
                    if (req_func == FUNC_INSERT)
                    begin
                        if (fill_reg >= CAP_F)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            ent_next   = '{id: req_id, count: req_count};
                            pos_next   = AW'(fill_reg);
                            fill_next  = fill_reg + FW'(1);
                            state_next = S_SIFT_RD;
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        raddr      = '0;
                        scan_next  = '0;
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                // rdata holds slot scan_reg
                if (cmp_eq)
                begin
                    ent_next.id    = rdata.id;
                    ent_next.count = (rdata.count == '1) ? rdata.count
                                                          : rdata.count + COUNT_W'(1);
                    pos_next       = scan_reg;
                    state_next     = S_SIFT_RD;
                end
                else if (scan_last)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    raddr     = scan_reg + AW'(1);
                    scan_next = scan_reg + AW'(1);
                end
            end

            S_SIFT_RD:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    raddr      = parent;
                    state_next = S_SIFT_CMP;
                end
            end

            S_SIFT_CMP:
            begin
                // rdata holds the parent slot
                cmp_a = ent_reg.count;
                cmp_b = rdata.count;
                we    = 1'b1;
                if (cmp_gt)
                begin
                    wdata      = rdata;
                    pos_next   = parent;
                    state_next = S_SIFT_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // shadow copy of the root slot
    always_comb
    begin
        root_next = root_reg;
        if (we && (waddr == '0))
        begin
            root_next = wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            pos_reg    <= '0;
            scan_reg   <= '0;
            id_reg     <= '0;
            ent_reg    <= '0;
            root_reg   <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            pos_reg    <= pos_next;
            scan_reg   <= scan_next;
            id_reg     <= id_next;
            ent_reg    <= ent_next;
            root_reg   <= root_next;
            status_reg <= status_next;
        end
    end

    // result fields; an empty heap reports a zero root
    assign ready            = (state_reg == S_IDLE);
    assign res_valid        = (state_reg == S_DONE);
    assign res.status       = status_reg;
    assign res.top_id       = (fill_reg == '0) ? '0 : root_reg.id;
    assign res.top_count    = (fill_reg == '0) ? '0 : root_reg.count;
    assign res.entry_count  = ECNT_W'(fill_reg);

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CAP_F)
        else $error("fill level above capacity");

    a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (FW'(scan_reg) < fill_reg))
        else $error("search past the last entry");

    a_write_in_sift: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> ((state_reg == S_SIFT_RD) || (state_reg == S_SIFT_CMP)))
        else $error("memory write outside sift");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !ready)
        else $error("ready right after accepting a request");

endmodule

`default_nettype wire

### hw/rtl/max_heap_increase_key_core.sv
`default_nettype none

// Binary max-heap of (identifier, count) entries. An insert request appends
// an entry and sifts it up; an increment request scans the slots from the
// root for the first matching identifier, bumps its count (saturating) and
// sifts it up. Each request yields one result with status, root entry and
// entry count. The heap lives in a memory with one write and one registered
// read port, and the sequencer reads at most one slot per cycle through one
// shared comparator. Sift-up reads the parent and compares counts at each
// level, moving the entry up while it is larger, and stops at the root or
// below a parent that is not smaller. An increment first scans from slot 0
// until a match or the last entry held; a miss goes straight to the result,
// as do a full-heap insert and an increment on an empty heap. The
// block takes no new request until the current one is finished; the
// finished result sits in an output register so the next request may enter
// while it waits. No clearing pass follows reset.
module max_heap_increase_key_core
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // item_id[15:0], start_count[47:16]
    input  wire logic        s_tuser,   // func[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // top_id[15:0], top_count[47:16],
                                        // entry_count[54:48], zero pad[55]
    output logic [1:0]       m_tuser    // status[1:0]
);
    import mhik_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FW = $clog2(CAPACITY + 1);

    logic        start;
    logic        ready;
    logic        res_valid;
    res_t        res;
    logic        out_free;
    func_t       req_func;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [55:0] m_tdata_reg,  m_tdata_next;
    logic [1:0]  m_tuser_reg,  m_tuser_next;

    assign s_tready = ready;
    assign start    = s_tvalid && ready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign req_func = func_t'(s_tuser);

    mhik_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .FW(FW)) u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_func  (req_func),
        .req_id    (s_tdata[15:0]),
        .req_count (s_tdata[47:16]),
        .ready     (ready),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (out_free)
    );

    // output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_free)
        begin
            m_tvalid_next = res_valid;
            if (res_valid)
            begin
                m_tdata_next = {1'b0, res.entry_count, res.top_count, res.top_id};
                m_tuser_next = res.status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
